[src/b64le_pkg.sv]
// Shared types, constants and the character table of the base64 line encoder.
package b64le_pkg;

    localparam int unsigned LINE_LEN_W = 10;
    localparam logic [LINE_LEN_W-1:0] LINE_LENGTH_RESET = 10'd72;
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  count;
        logic        last;
    } b64le_group_t;

    function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

[src/base64_line_encoder.sv]
// Top level of the streaming base64 encoder with line wrapping.
//
// Bytes enter on the s_axis channel, with tlast set on the final byte of a
// stream. Characters leave on the m_axis channel, one per transfer, with
// tlast on the fourth character of each group and tuser flags for the start
// of a line and the end of the whole encoding. The line length register is
// written via cfg_wr_en and cfg_wr_data, by the user only while the block is
// idle, which the block does not enforce. A byte that completes a group, or
// ends the stream, is pushed into the group queue and its first character is
// then registered on m_axis; other bytes are only buffered. The output carries
// one character per cycle while the receiver keeps tready high, so three bytes
// become four characters; the input accepts one byte per cycle until the
// two-entry group queue fills. Reset clears the buffered bytes, the queue, the
// line position and sets the line length to 72. When the receiver stalls, the
// current character holds on m_axis, the queue fills and s_axis_tready falls.
module base64_line_encoder (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [b64le_pkg::LINE_LEN_W-1:0] cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,  // [7:0] data_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,  // [7:0] symbol
    output logic [1:0]                       m_axis_tuser,  // [0] line_start, [1] stream_end
    output logic                             m_axis_tlast
);
    import b64le_pkg::*;

    b64le_group_t push_group;
    b64le_group_t head_group;
    logic         push;
    logic         pop;
    logic         queue_full;
    logic         head_valid;
    logic         line_start;
    logic         stream_end;

    b64le_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .data_byte  (s_axis_tdata),
        .last_byte  (s_axis_tlast),
        .push       (push),
        .push_group (push_group),
        .queue_full (queue_full)
    );

    b64le_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_group (head_group)
    );

    b64le_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_valid  (head_valid),
        .head_group  (head_group),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .symbol      (m_axis_tdata),
        .line_start  (line_start),
        .run_last    (m_axis_tlast),
        .stream_end  (stream_end)
    );

    assign m_axis_tuser = {stream_end, line_start};

endmodule

[src/b64le_front.sv]
// Front part: collects input bytes into groups of up to three and hands them on.
module b64le_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    output logic                  push,
    output b64le_pkg::b64le_group_t push_group,
    input  logic                  queue_full
);
    import b64le_pkg::*;

    logic [7:0] pend0_reg, pend0_next;
    logic [7:0] pend1_reg, pend1_next;
    logic [1:0] pend_count_reg, pend_count_next;
    logic       accept;
    logic [7:0] g0, g1, g2;
    logic       group_done;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        g0 = (pend_count_reg == 2'd0) ? data_byte : pend0_reg;
        g1 = (pend_count_reg == 2'd1) ? data_byte :
             ((pend_count_reg == 2'd2) ? pend1_reg : 8'h00);
        g2 = (pend_count_reg == 2'd2) ? data_byte : 8'h00;
        group_done = last_byte || (pend_count_reg == 2'd2);

        push             = accept && group_done;
        push_group.bits  = {g0, g1, g2};
        push_group.count = pend_count_reg + 2'd1;
        push_group.last  = last_byte;

        pend0_next      = pend0_reg;
        pend1_next      = pend1_reg;
        pend_count_next = pend_count_reg;
        if (accept) begin
            if (group_done) begin
                pend0_next      = 8'h00;
                pend1_next      = 8'h00;
                pend_count_next = 2'd0;
            end else begin
                if (pend_count_reg == 2'd0) begin
                    pend0_next = data_byte;
                end else begin
                    pend1_next = data_byte;
                end
                pend_count_next = pend_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend0_reg      <= 8'h00;
            pend1_reg      <= 8'h00;
            pend_count_reg <= 2'd0;
        end else begin
            pend0_reg      <= pend0_next;
            pend1_reg      <= pend1_next;
            pend_count_reg <= pend_count_next;
        end
    end

endmodule

[src/b64le_queue.sv]
// Two-entry queue of byte groups between the front and back parts.
module b64le_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  b64le_pkg::b64le_group_t push_group,
    output logic                    full,
    input  logic                    pop,
    output logic                    head_valid,
    output b64le_pkg::b64le_group_t head_group
);
    import b64le_pkg::*;

    b64le_group_t entry_reg [2];
    logic         wr_ptr_reg, wr_ptr_next;
    logic         rd_ptr_reg, rd_ptr_next;
    logic [1:0]   count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_group = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_group;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[src/b64le_back.sv]
// Back part: turns each group into four characters with line tracking.
module b64le_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [b64le_pkg::LINE_LEN_W-1:0]   cfg_wr_data,
    input  logic                               head_valid,
    input  b64le_pkg::b64le_group_t            head_group,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         symbol,
    output logic                               line_start,
    output logic                               run_last,
    output logic                               stream_end
);
    import b64le_pkg::*;

    logic [LINE_LEN_W-1:0] line_length_reg;
    logic [LINE_LEN_W-1:0] line_fill_reg, line_fill_next;
    logic [1:0]            idx_reg, idx_next;
    logic                  valid_reg, valid_next;
    logic [7:0]            symbol_reg, symbol_next;
    logic                  start_reg, start_next;
    logic                  run_last_reg, run_last_next;
    logic                  end_reg, end_next;
    logic                  advance;
    logic [5:0]            sextet;
    logic [LINE_LEN_W-1:0] fill_eff;

    assign out_valid  = valid_reg;
    assign symbol     = symbol_reg;
    assign line_start = start_reg;
    assign run_last   = run_last_reg;
    assign stream_end = end_reg;

    assign advance = head_valid && (!valid_reg || out_ready);
    assign pop     = advance && (idx_reg == 2'd3);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = head_group.bits[23:18];
            2'd1:    sextet = head_group.bits[17:12];
            2'd2:    sextet = head_group.bits[11:6];
            2'd3:    sextet = head_group.bits[5:0];
            default: sextet = 6'd0;
        endcase
        fill_eff = (line_fill_reg >= line_length_reg) ? '0 : line_fill_reg;

        valid_next     = valid_reg;
        symbol_next    = symbol_reg;
        start_next     = start_reg;
        run_last_next  = run_last_reg;
        end_next       = end_reg;
        idx_next       = idx_reg;
        line_fill_next = line_fill_reg;
        if (advance) begin
            valid_next     = 1'b1;
            symbol_next    = (idx_reg <= head_group.count) ? sextet_to_char(sextet) : PAD_CHAR;
            start_next     = (fill_eff == '0);
            run_last_next  = (idx_reg == 2'd3);
            end_next       = (idx_reg == 2'd3) && head_group.last;
            idx_next       = idx_reg + 2'd1;
            line_fill_next = fill_eff + 1'b1;
            if ((idx_reg == 2'd3) && head_group.last) begin
                line_fill_next = '0;
            end
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        symbol_reg   <= symbol_next;
        start_reg    <= start_next;
        run_last_reg <= run_last_next;
        end_reg      <= end_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_length_reg <= LINE_LENGTH_RESET;
            line_fill_reg   <= '0;
            idx_reg         <= 2'd0;
            valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                line_length_reg <= cfg_wr_data;
            end
            line_fill_reg <= line_fill_next;
            idx_reg       <= idx_next;
            valid_reg     <= valid_next;
        end
    end

endmodule

[src/b64le_checker.sv]
// Port-level checks of the base64 line encoder and their attachment.
module b64le_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,
    input  logic [1:0] m_axis_tuser,
    input  logic       m_axis_tlast
);
    import b64le_pkg::*;

    // A stalled character stays in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output changed");

    // The end of the encoding always closes a group.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
        else $error("stream end without group end");

    // The character after the end of an encoding begins a new line.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[1] |=>
            !m_axis_tvalid || m_axis_tuser[0])
        else $error("new stream did not start a line");

    // Padding inside a group is followed only by more padding.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && (m_axis_tdata == PAD_CHAR) && !m_axis_tlast |=>
            !m_axis_tvalid || (m_axis_tdata == PAD_CHAR))
        else $error("data character after padding");

endmodule

bind base64_line_encoder b64le_checker u_b64le_checker (.*);
